// ===== design/wbc_pkg.sv =====
package wbc_pkg;

  // field widths
  localparam int VALUE_WIDTH = 32;
  localparam int WEIGHT_W    = 16;
  localparam int WSUM_W      = 40;
  localparam int ACC_W       = 64;
  localparam int OUT_W       = 48;
  localparam int MAG_W       = VALUE_WIDTH + 1;

  // shared multiply / divide unit sizing
  localparam int MUL_B_W   = (MAG_W > WSUM_W) ? MAG_W : WSUM_W;
  localparam int PROD_W    = ACC_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int DIV_STEPS = ACC_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // stream packing
  localparam int IN_BITS     = 2 * VALUE_WIDTH + WEIGHT_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = WSUM_W + 2 * VALUE_WIDTH + 3 * OUT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // request to the shared unit
  typedef struct packed {
    logic start;
    logic is_div;
  } wbc_req_t;

endpackage

// ===== design/weighted_bivariate_covariance_core.sv =====
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: value_x, value_y, weight; s_tlast: last
// m        out  m_tvalid/m_tready  m_tdata: weight..covariance; m_tuser: saturated
//
// each sample runs through one shared shift-add multiplier / restoring divider:
// eight multiplies and two divides per sample; a last sample adds three divides
// and an emit step.
// s_tready is high only while the sequencer is idle.
// synchronous reset clears the running statistics and the output valid.
// a result waiting on m_tready holds the sequencer only when the next result is due.
module weighted_bivariate_covariance_core import wbc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_TDATA_W-1:0]   s_tdata,   // value_x, value_y, weight
  input  logic                    s_tlast,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata,   // total_weight, mean_x, mean_y,
                                             // variance_x, variance_y, covariance
  output logic                    m_tuser    // saturated
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_PREP   = 5'd1;
  localparam logic [4:0] ST_MXW    = 5'd2;
  localparam logic [4:0] ST_DXN    = 5'd3;
  localparam logic [4:0] ST_MYW    = 5'd4;
  localparam logic [4:0] ST_DYN    = 5'd5;
  localparam logic [4:0] ST_SQX    = 5'd6;
  localparam logic [4:0] ST_MNX    = 5'd7;
  localparam logic [4:0] ST_SQY    = 5'd8;
  localparam logic [4:0] ST_MNY    = 5'd9;
  localparam logic [4:0] ST_DY2    = 5'd10;
  localparam logic [4:0] ST_CXY    = 5'd11;
  localparam logic [4:0] ST_CW     = 5'd12;
  localparam logic [4:0] ST_COMMIT = 5'd13;
  localparam logic [4:0] ST_VX     = 5'd14;
  localparam logic [4:0] ST_VY     = 5'd15;
  localparam logic [4:0] ST_CV     = 5'd16;
  localparam logic [4:0] ST_EMIT   = 5'd17;

  localparam logic [ACC_W-1:0]      ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] ACC_MAX_S = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] ACC_MIN_S = -ACC_MAX_S;
  localparam logic [OUT_W-1:0]      VAR_MAX   = {OUT_W{1'b1}};
  localparam logic [OUT_W-1:0]      COV_POS   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]      COV_NEG   = {1'b1, {(OUT_W-1){1'b0}}};

  logic [4:0] state;
  logic       issued;

  // accepted sample
  logic signed [VALUE_WIDTH-1:0] in_x, in_y;
  logic [WEIGHT_W-1:0]           in_w;
  logic                          in_last;

  // running statistics
  logic [WSUM_W-1:0]             ws;
  logic signed [VALUE_WIDTH-1:0] mx, my;
  logic signed [ACC_W-1:0]       mom_x, mom_y, comom;
  logic                          clip;

  // per-sample working registers
  logic [WSUM_W-1:0]  nn;
  logic               wclip, sat_acc, osat;
  logic [MAG_W-1:0]   adx, ady, ady2, ox, oy;
  logic               sx, sy, sy2;
  logic [ACC_W-1:0]   tmp;
  logic [OUT_W-1:0]   vxo, vyo, cov;

  // shared unit
  wbc_req_t             req;
  logic [ACC_W-1:0]     op_a;
  logic [MUL_B_W-1:0]   op_b;
  logic [PROD_W-1:0]    res;
  logic                 done;

  wbc_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (op_a),
    .b    (op_b),
    .res  (res),
    .done (done)
  );

  // prep arithmetic
  logic [WSUM_W:0]                nn_sum;
  logic signed [VALUE_WIDTH:0]    dx, dy, dy2;
  always_comb begin
    nn_sum = {1'b0, ws} + (WSUM_W+1)'(in_w);
    dx     = {in_x[VALUE_WIDTH-1], in_x} - {mx[VALUE_WIDTH-1], mx};
    dy     = {in_y[VALUE_WIDTH-1], in_y} - {my[VALUE_WIDTH-1], my};
    dy2    = {in_y[VALUE_WIDTH-1], in_y} - {my[VALUE_WIDTH-1], my};
  end

  // mean updates
  logic signed [VALUE_WIDTH+1:0] mx_ext, my_ext;
  always_comb begin
    mx_ext = sx ? ((VALUE_WIDTH+2)'(mx) - (VALUE_WIDTH+2)'(ox))
                : ((VALUE_WIDTH+2)'(mx) + (VALUE_WIDTH+2)'(ox));
    my_ext = sy ? ((VALUE_WIDTH+2)'(my) - (VALUE_WIDTH+2)'(oy))
                : ((VALUE_WIDTH+2)'(my) + (VALUE_WIDTH+2)'(oy));
  end

  // scaled square or cross product, truncated by 2^16 and saturated to 64 bits
  logic             sq_sat;
  logic [ACC_W-1:0] sq_val;
  always_comb begin
    sq_sat = |res[PROD_W-1:ACC_W+16];
    sq_val = sq_sat ? {ACC_W{1'b1}} : res[ACC_W+15:16];
  end

  // product saturation and accumulator adds
  logic               t_sat, tm_sat, m_ovf, c_sat;
  logic [ACC_W-1:0]   t64, tm;
  logic signed [ACC_W-1:0] mom_sel, mom_new, sv, comom_new;
  logic signed [ACC_W:0]   msum, csum;
  always_comb begin
    t_sat   = |res[PROD_W-1:ACC_W];
    t64     = t_sat ? {ACC_W{1'b1}} : res[ACC_W-1:0];
    tm_sat  = t64[ACC_W-1];
    tm      = tm_sat ? ACC_MAX : t64;
    mom_sel = (state == ST_MNX) ? mom_x : mom_y;
    msum    = {mom_sel[ACC_W-1], mom_sel} + {1'b0, tm};
    m_ovf   = (msum > ACC_MAX_S);
    mom_new = m_ovf ? $signed(ACC_MAX) : msum[ACC_W-1:0];
    sv      = (sx ^ sy2) ? -$signed(tm) : $signed(tm);
    csum    = {comom[ACC_W-1], comom} + {sv[ACC_W-1], sv};
    c_sat   = 1'b0;
    comom_new = csum[ACC_W-1:0];
    if (csum > ACC_MAX_S) begin
      c_sat     = 1'b1;
      comom_new = $signed(ACC_MAX);
    end else if (csum < ACC_MIN_S) begin
      c_sat     = 1'b1;
      comom_new = -$signed(ACC_MAX);
    end
  end

  // quotient clamps for the result
  logic [ACC_W-1:0] q;
  logic [OUT_W-1:0] vq, cq;
  logic             vq_sat, cq_sat;
  always_comb begin
    q      = res[ACC_W-1:0];
    vq_sat = |q[ACC_W-1:OUT_W];
    vq     = vq_sat ? VAR_MAX : q[OUT_W-1:0];
    if (comom[ACC_W-1]) begin
      cq_sat = (q > ACC_W'(COV_NEG));
      cq     = cq_sat ? COV_NEG : q[OUT_W-1:0];
      cq     = OUT_W'(0) - cq;
    end else begin
      cq_sat = (q > ACC_W'(COV_POS));
      cq     = cq_sat ? COV_POS : q[OUT_W-1:0];
    end
  end

  // operand selection for the shared unit
  logic op_state, skip_div;
  always_comb begin
    op_a       = '0;
    op_b       = '0;
    req.is_div = 1'b0;
    op_state   = 1'b1;
    case (state)
      ST_MXW: begin op_a = ACC_W'(adx); op_b = MUL_B_W'(in_w); end
      ST_DXN: begin op_a = tmp; op_b = MUL_B_W'(nn); req.is_div = 1'b1; end
      ST_MYW: begin op_a = ACC_W'(ady); op_b = MUL_B_W'(in_w); end
      ST_DYN: begin op_a = tmp; op_b = MUL_B_W'(nn); req.is_div = 1'b1; end
      ST_SQX: begin op_a = ACC_W'(adx); op_b = MUL_B_W'(ox); end
      ST_MNX: begin op_a = tmp; op_b = MUL_B_W'(ws); end
      ST_SQY: begin op_a = ACC_W'(ady); op_b = MUL_B_W'(oy); end
      ST_MNY: begin op_a = tmp; op_b = MUL_B_W'(ws); end
      ST_CXY: begin op_a = ACC_W'(adx); op_b = MUL_B_W'(ady2); end
      ST_CW:  begin op_a = tmp; op_b = MUL_B_W'(in_w); end
      ST_VX: begin
        op_a = mom_x[ACC_W-1] ? '0 : mom_x;
        op_b = MUL_B_W'(ws);
        req.is_div = 1'b1;
      end
      ST_VY: begin
        op_a = mom_y[ACC_W-1] ? '0 : mom_y;
        op_b = MUL_B_W'(ws);
        req.is_div = 1'b1;
      end
      ST_CV: begin
        op_a = comom[ACC_W-1] ? ACC_W'(-comom) : comom;
        op_b = MUL_B_W'(ws);
        req.is_div = 1'b1;
      end
      default: op_state = 1'b0;
    endcase
    skip_div  = (state == ST_VX) && (ws == '0);
    req.start = op_state && !issued && !skip_div;
  end

  assign s_tready = (state == ST_IDLE);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issued   <= 1'b0;
      m_tvalid <= 1'b0;
      ws       <= '0;
      mx       <= '0;
      my       <= '0;
      mom_x    <= '0;
      mom_y    <= '0;
      comom    <= '0;
      clip     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_EMIT) m_tvalid <= 1'b0;
      if (req.start) issued <= 1'b1;
      if (done) issued <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_x    <= s_tdata[VALUE_WIDTH-1:0];
            in_y    <= s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
            in_w    <= s_tdata[IN_BITS-1:2*VALUE_WIDTH];
            in_last <= s_tlast;
            state   <= ST_PREP;
          end
        end
        ST_PREP: begin
          wclip   <= nn_sum[WSUM_W];
          nn      <= nn_sum[WSUM_W] ? {WSUM_W{1'b1}} : nn_sum[WSUM_W-1:0];
          sx      <= dx[VALUE_WIDTH];
          sy      <= dy[VALUE_WIDTH];
          adx     <= dx[VALUE_WIDTH] ? MAG_W'(-dx) : MAG_W'(dx);
          ady     <= dy[VALUE_WIDTH] ? MAG_W'(-dy) : MAG_W'(dy);
          sat_acc <= 1'b0;
          osat    <= 1'b0;
          // a sample that leaves the weight at zero is skipped
          if (nn_sum == '0) state <= in_last ? ST_VX : ST_IDLE;
          else state <= ST_MXW;
        end
        ST_MXW: if (done) begin tmp <= res[ACC_W-1:0]; state <= ST_DXN; end
        ST_DXN: if (done) begin
          ox    <= res[MAG_W-1:0];
          state <= ST_MYW;
        end
        ST_MYW: if (done) begin
          mx    <= mx_ext[VALUE_WIDTH-1:0];
          tmp   <= res[ACC_W-1:0];
          state <= ST_DYN;
        end
        ST_DYN: if (done) begin oy <= res[MAG_W-1:0]; state <= ST_SQX; end
        ST_SQX: if (done) begin
          my      <= my_ext[VALUE_WIDTH-1:0];
          tmp     <= sq_val;
          sat_acc <= sat_acc | sq_sat;
          state   <= ST_MNX;
        end
        ST_MNX: if (done) begin
          mom_x   <= mom_new;
          sat_acc <= sat_acc | t_sat | tm_sat | m_ovf;
          state   <= ST_SQY;
        end
        ST_SQY: if (done) begin
          tmp     <= sq_val;
          sat_acc <= sat_acc | sq_sat;
          state   <= ST_MNY;
        end
        ST_MNY: if (done) begin
          mom_y   <= mom_new;
          sat_acc <= sat_acc | t_sat | tm_sat | m_ovf;
          state   <= ST_DY2;
        end
        ST_DY2: begin
          sy2   <= dy2[VALUE_WIDTH];
          ady2  <= dy2[VALUE_WIDTH] ? MAG_W'(-dy2) : MAG_W'(dy2);
          state <= ST_CXY;
        end
        ST_CXY: if (done) begin
          tmp     <= sq_val;
          sat_acc <= sat_acc | sq_sat;
          state   <= ST_CW;
        end
        ST_CW: if (done) begin
          comom   <= comom_new;
          sat_acc <= sat_acc | t_sat | tm_sat | c_sat;
          state   <= ST_COMMIT;
        end
        ST_COMMIT: begin
          ws    <= nn;
          clip  <= clip | sat_acc | wclip;
          state <= in_last ? ST_VX : ST_IDLE;
        end
        ST_VX: begin
          // no weight: every statistic reads zero
          if (skip_div) begin
            vxo   <= '0;
            vyo   <= '0;
            cov   <= '0;
            state <= ST_EMIT;
          end else if (done) begin
            vxo   <= vq;
            osat  <= osat | vq_sat;
            state <= ST_VY;
          end
        end
        ST_VY: if (done) begin
          vyo   <= vq;
          osat  <= osat | vq_sat;
          state <= ST_CV;
        end
        ST_CV: if (done) begin
          cov   <= cq;
          osat  <= osat | cq_sat;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TDATA_W'({cov, vyo, vxo, my, mx, ws});
            m_tuser  <= clip | osat;
            ws       <= '0;
            mx       <= '0;
            my       <= '0;
            mom_x    <= '0;
            mom_y    <= '0;
            comom    <= '0;
            clip     <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the shared unit only finishes work that was issued
  a_done_issued: assert property (@(posedge clk) disable iff (rst) done |-> issued)
    else $error("shared unit finished without a request");

  // a new transaction is not taken in the cycle after one was accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a sample is in work");

  // second moments never go negative
  a_moment_sign: assert property (@(posedge clk) disable iff (rst)
    !mom_x[ACC_W-1] && !mom_y[ACC_W-1])
    else $error("second moment went negative");
`endif

endmodule

// ===== design/wbc_mdu.sv =====
module wbc_mdu import wbc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  wbc_req_t            req,
  input  logic [ACC_W-1:0]    a,
  input  logic [MUL_B_W-1:0]  b,
  output logic [PROD_W-1:0]   res,
  output logic                done
);

  logic                busy;
  logic                is_div;
  logic [CNT_W-1:0]    cnt;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mcand;
  logic [MUL_B_W-1:0]  mplier;
  logic [WSUM_W-1:0]   rem;
  logic [ACC_W-1:0]    quo;
  logic [WSUM_W-1:0]   dvs;
  logic [WSUM_W:0]     r2;
  logic                qbit;

  // one restoring division step
  always_comb begin
    r2   = {rem, quo[ACC_W-1]};
    qbit = (r2 >= {1'b0, dvs});
  end

  // shift-add multiply or restoring divide, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= PROD_W'(a);
        mplier <= b;
        quo    <= a;
        rem    <= '0;
        dvs    <= b[WSUM_W-1:0];
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (is_div) begin
          rem <= qbit ? WSUM_W'(r2 - {1'b0, dvs}) : r2[WSUM_W-1:0];
          quo <= {quo[ACC_W-2:0], qbit};
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= {mcand[PROD_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MUL_B_W-1:1]};
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign res = is_div ? PROD_W'(quo) : acc;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// running-statistics predictor and store of expected set summaries
class cov_scoreboard;
  logic [wbc_pkg::OUT_TDATA_W-1:0] exp_data[$];
  logic                            exp_sat[$];
  int unsigned mismatches;
  int unsigned sets_seen;
  int unsigned sat_seen;

  logic [63:0] wsum;
  logic signed [63:0] mx, my, mom_x, mom_y, comom;
  bit clip;

  localparam logic [63:0] WSUM_MAX = (64'd1 << 40) - 1;
  localparam logic [63:0] OUT_MAX  = (64'd1 << 48) - 1;
  localparam logic [63:0] COV_POS  = (64'd1 << 47) - 1;
  localparam logic [63:0] COV_NEG  = (64'd1 << 47);
  localparam logic [63:0] I64_MAX  = 64'h7fff_ffff_ffff_ffff;

  function void clear_stats();
    wsum = 0; mx = 0; my = 0; mom_x = 0; mom_y = 0; comom = 0; clip = 0;
  endfunction

  function logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // exact floor(a*b/d), saturating to all ones
  function logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                    inout bit sat);
    logic [127:0] q;
    if (d == 0) begin
      sat = 1;
      return '1;
    end
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
    if (q[127:64] != 0) begin
      sat = 1;
      return '1;
    end
    return q[63:0];
  endfunction

  function logic [63:0] clamped_mul(logic [63:0] a, logic [63:0] b, inout bit sat);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != 0) begin
      sat = 1;
      return '1;
    end
    return p[63:0];
  endfunction

  function logic signed [63:0] signed_term(logic [63:0] m, bit neg, inout bit sat);
    if (m > I64_MAX) begin
      sat = 1;
      m = I64_MAX;
    end
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function logic signed [63:0] clamped_add(logic signed [63:0] a, logic signed [63:0] b,
                                           inout bit sat);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, I64_MAX})) begin
      sat = 1;
      return $signed(I64_MAX);
    end
    if (s < -$signed({1'b0, I64_MAX})) begin
      sat = 1;
      return -$signed(I64_MAX);
    end
    return s[63:0];
  endfunction

  function logic [63:0] variance_of(logic signed [63:0] m, inout bit sat);
    logic [63:0] q;
    if (m <= 0) return 0;
    q = m / wsum;
    if (q > OUT_MAX) begin
      sat = 1;
      q = OUT_MAX;
    end
    return q;
  endfunction

  // note one accepted sample transaction
  function void note_sample(logic signed [31:0] vx, logic signed [31:0] vy,
                            logic [15:0] w, bit last);
    logic [63:0] n, nn, ox, oy, t, cm, vxo, vyo, cov;
    logic signed [63:0] dx, dy, dy2;
    bit sat, osat;
    sat = 0; osat = 0;
    n = wsum;
    nn = n + w;
    if (nn > WSUM_MAX) begin
      nn = WSUM_MAX;
      clip = 1;
    end
    if (nn != 0) begin
      dx = 64'(vx) - mx;
      dy = 64'(vy) - my;
      ox = scaled_quot(magnitude(dx), 64'(w), nn, sat);
      oy = scaled_quot(magnitude(dy), 64'(w), nn, sat);
      mx = mx + (dx < 0 ? -$signed(ox) : $signed(ox));
      my = my + (dy < 0 ? -$signed(oy) : $signed(oy));
      t = clamped_mul(scaled_quot(magnitude(dx), ox, 65536, sat), n, sat);
      mom_x = clamped_add(mom_x, signed_term(t, 0, sat), sat);
      t = clamped_mul(scaled_quot(magnitude(dy), oy, 65536, sat), n, sat);
      mom_y = clamped_add(mom_y, signed_term(t, 0, sat), sat);
      dy2 = 64'(vy) - my;
      t = clamped_mul(scaled_quot(magnitude(dx), magnitude(dy2), 65536, sat), 64'(w), sat);
      comom = clamped_add(comom, signed_term(t, (dx < 0) != (dy2 < 0), sat), sat);
      wsum = nn;
      if (sat) clip = 1;
    end
    if (!last) return;
    vxo = 0; vyo = 0; cov = 0;
    if (wsum != 0) begin
      cm = magnitude(comom) / wsum;
      vxo = variance_of(mom_x, osat);
      vyo = variance_of(mom_y, osat);
      if (comom < 0) begin
        if (cm > COV_NEG) begin
          osat = 1;
          cm = COV_NEG;
        end
        cov = (-cm) & OUT_MAX;
      end else begin
        if (cm > COV_POS) begin
          osat = 1;
          cm = COV_POS;
        end
        cov = cm;
      end
    end
    exp_data.push_back({cov[47:0], vyo[47:0], vxo[47:0], my[31:0], mx[31:0], wsum[39:0]});
    exp_sat.push_back(clip | osat);
    clear_stats();
  endfunction

  // compare one result transaction with the oldest expected summary
  function void check_summary(logic [wbc_pkg::OUT_TDATA_W-1:0] data, logic sat);
    logic [wbc_pkg::OUT_TDATA_W-1:0] e;
    logic es;
    sets_seen++;
    if (exp_data.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h sat %b", data, sat);
      return;
    end
    e = exp_data.pop_front();
    es = exp_sat.pop_front();
    if (es) sat_seen++;
    if (data !== e || sat !== es) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch weight exp %h got %h, mean_x exp %h got %h, mean_y exp %h got %h",
                 e[39:0], data[39:0], e[71:40], data[71:40], e[103:72], data[103:72]);
        $display("  var_x exp %h got %h, var_y exp %h got %h, cov exp %h got %h, sat %b/%b",
                 e[151:104], data[151:104], e[199:152], data[199:152],
                 e[247:200], data[247:200], es, sat);
      end
    end
  endfunction
endclass

module tb_top;
  import wbc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  cov_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned samples_sent = 0;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  weighted_bivariate_covariance_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side: random ready stalls, check each transaction
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_summary(m_tdata, m_tuser);
    end
  end

  // send one sample transaction, then drop valid unless the next follows at once
  task automatic send_sample(logic [31:0] vx, logic [31:0] vy, logic [15:0] w, bit last);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {w, vy, vx};
    s_tlast <= last;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(vx, vy, w, last);
    samples_sent++;
  endtask

  task automatic idle_sender();
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 20))) - 32'd1310720;
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(0, 255)) << 16;
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd256;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    int len, mode;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty set with zero weight, extremes, clipping cases
    send_sample(32'h0, 32'h0, 16'h0, 1);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 16'hffff, 0);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 0);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 16'h0001, 1);
    send_sample(32'h0001_0000, 32'h0002_0000, 16'h0100, 1);
    send_sample(32'h1234_5678, 32'hfedc_ba98, 16'h0, 0);
    send_sample(32'h0003_0000, 32'hfffd_0000, 16'h0100, 0);
    send_sample(32'hfffd_0000, 32'h0003_0000, 16'h0200, 0);
    send_sample(32'h0, 32'h0, 16'h0, 0);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'h8000, 1);
    for (int i = 0; i < 6; i++)
      send_sample($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000,
                  $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000, 16'hffff, i == 5);
    send_sample(32'hffff_ffff, 32'h0000_0001, 16'h0001, 1);

    // hold off until every summary has come back
    idle_sender();
    while (sb.exp_data.size() != 0) @(posedge clk);

    // random sets, mostly short, with a random value mode per set
    while (samples_sent < 950) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < len; k++)
        send_sample(rand_value($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode),
                    rand_value($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode),
                    rand_weight(), k == len - 1);
      if ($urandom_range(0, 15) == 0) begin
        idle_sender();
        while (sb.exp_data.size() != 0) @(posedge clk);
      end
    end
    idle_sender();

    while (sb.exp_data.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);

    $display("run covered %0d samples in %0d sets, %0d of them with a saturation flag",
             samples_sent, sb.sets_seen, sb.sat_seen);
    if (sb.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_top: errors");
    end
    $finish;
  end

  initial sb.clear_stats();
endmodule
